// ===== design/box_average_downscale_unit_assert.svh =====
// assertion macros for the box average downscale unit
`ifndef BOX_AVERAGE_DOWNSCALE_UNIT_ASSERT_SVH
`define BOX_AVERAGE_DOWNSCALE_UNIT_ASSERT_SVH

// consequent checked in the same cycle
`define BOXAVG_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define BOXAVG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/boxavg_pkg.sv =====
// shared constants, types and control bundles of the box average downscaler
package boxavg_pkg;

  localparam int MAX_WIDTH = 4096;
  localparam int MAX_BLOCK = 16;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int DIM_W  = COL_W + 1;
  localparam int OFS_W  = $clog2(MAX_BLOCK);
  localparam int BLK_W  = OFS_W + 1;
  localparam int CH_W   = 8;
  localparam int SUM_W  = CH_W + 2 * OFS_W;
  localparam int AREA_W = 2 * OFS_W + 1;
  localparam int CFG_W  = DIM_W;
  localparam int CFG_IDX_W = 2;

  localparam int LANES      = 3;
  localparam int LANE_RED   = 0;
  localparam int LANE_GREEN = 1;
  localparam int LANE_BLUE  = 2;

  localparam int RESET_IMAGE_WIDTH  = 640;
  localparam int RESET_IMAGE_HEIGHT = 480;
  localparam int RESET_BLOCK_WIDTH  = 2;
  localparam int RESET_BLOCK_HEIGHT = 2;
  localparam int RESET_NEW_WIDTH    = RESET_IMAGE_WIDTH / RESET_BLOCK_WIDTH;
  localparam int RESET_USED_ROWS    =
    (RESET_IMAGE_HEIGHT / RESET_BLOCK_HEIGHT) * RESET_BLOCK_HEIGHT;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_BLOCK_WIDTH  = 2'd2,
    REG_BLOCK_HEIGHT = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic clear_en;
    logic accept;
    logic update;
    logic avg_start;
    logic derive_start;
    logic derive_load;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic cfg_pending;
    logic emit;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

// ===== design/boxavg_pixel_if.sv =====
// input pixel channel
interface boxavg_pixel_if;
  import boxavg_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red_in;
  logic [CH_W-1:0] green_in;
  logic [CH_W-1:0] blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  input ready);
  modport sink (input valid, input red_in, input green_in, input blue_in,
                output ready);
endinterface

// ===== design/boxavg_result_if.sv =====
// output block average channel
interface boxavg_result_if;
  import boxavg_pkg::*;

  logic             valid;
  logic             ready;
  logic [CH_W-1:0]  red_out;
  logic [CH_W-1:0]  green_out;
  logic [CH_W-1:0]  blue_out;
  logic [COL_W-1:0] out_column;
  logic             row_end;
  logic             frame_end;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output out_column, output row_end, output frame_end,
                  input ready);
  modport sink (input valid, input red_out, input green_out, input blue_out,
                input out_column, input row_end, input frame_end,
                output ready);
endinterface

// ===== design/box_average_downscale_unit.sv =====
// top level of the box average downscaler
//
// pixels enter on the pixel channel in raster order, one per transaction;
// block averages leave on the result channel with their downscaled column
// and row and frame end marks. settings are written on the cfg_we port
// (cfg_index selects the register, cfg_data carries the value).
// an ordinary pixel runs through the transaction cycle, which reads the
// column accumulator ram, then the cycle that writes the updated sums back.
// the pixel that closes a block also runs the shared divider, one quotient
// bit per cycle over 16 bits; once it is done the result is loaded into
// the output register, and only then is the next pixel taken.
// after reset the accumulator ram is cleared one column per cycle over all
// 4096 columns, with pixel ready low. each settings write makes the block
// recompute its block grid on the divider, again with pixel ready low.
// a finished result sits in an output register; pixels are still taken while
// it waits, and a following result waits until the register is free.
module box_average_downscale_unit (
  input  logic                         clk,
  input  logic                         rst,
  boxavg_pixel_if.sink                 pixel,
  boxavg_result_if.source              result,
  input  logic                         cfg_we,
  input  boxavg_pkg::cfg_reg_t         cfg_index,
  input  logic [boxavg_pkg::CFG_W-1:0] cfg_data
);
  import boxavg_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;
  logic       in_ready;

  assign pixel.ready = in_ready;

  boxavg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pixel.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  boxavg_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .red_in     (pixel.red_in),
    .green_in   (pixel.green_in),
    .blue_in    (pixel.blue_in),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .red_out    (result.red_out),
    .green_out  (result.green_out),
    .blue_out   (result.blue_out),
    .out_column (result.out_column),
    .row_end    (result.row_end),
    .frame_end  (result.frame_end)
  );

endmodule

// ===== design/boxavg_ram.sv =====
// generic single write port ram with registered read
module boxavg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/boxavg_divider.sv =====
// multi-lane restoring divider, one quotient bit per cycle
module boxavg_divider (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [boxavg_pkg::LANES-1:0][boxavg_pkg::SUM_W-1:0]  dividend,
  input  logic [boxavg_pkg::LANES-1:0][boxavg_pkg::AREA_W-1:0] divisor,
  output logic [boxavg_pkg::LANES-1:0][boxavg_pkg::SUM_W-1:0]  quotient,
  output logic done
);
  import boxavg_pkg::*;

  localparam int CNT_W = $clog2(SUM_W);

  logic [LANES-1:0][AREA_W-1:0] rem;
  logic [LANES-1:0][AREA_W-1:0] rem_next;
  logic [LANES-1:0][AREA_W-1:0] dsr;
  logic [LANES-1:0][SUM_W-1:0]  quo_next;
  logic [CNT_W-1:0]             cnt;
  logic                         busy;

  always_comb begin
    logic [AREA_W:0] shifted;
    logic [AREA_W:0] diff;
    for (int i = 0; i < LANES; i++) begin
      shifted = {rem[i], quotient[i][SUM_W-1]};
      diff    = shifted - {1'b0, dsr[i]};
      if (!diff[AREA_W]) begin
        rem_next[i] = diff[AREA_W-1:0];
        quo_next[i] = {quotient[i][SUM_W-2:0], 1'b1};
      end else begin
        rem_next[i] = shifted[AREA_W-1:0];
        quo_next[i] = {quotient[i][SUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == CNT_W'(SUM_W - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(SUM_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dsr      <= divisor;
    end else if (busy) begin
      quotient <= quo_next;
      rem      <= rem_next;
    end
  end

endmodule

// ===== design/boxavg_ctrl.sv =====
// controller state machine of the box average downscaler
module boxavg_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  boxavg_pkg::dp_status_t sts,
  output boxavg_pkg::ctrl_cmd_t  cmd
);
  import boxavg_pkg::*;

  typedef enum logic [5:0] {
    ST_CLEAR   = 6'b000001,
    ST_IDLE    = 6'b000010,
    ST_READ    = 6'b000100,
    ST_AVERAGE = 6'b001000,
    ST_EMIT    = 6'b010000,
    ST_DERIVE  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (sts.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (sts.cfg_pending) begin
          cmd.derive_start = 1'b1;
          state_next       = ST_DERIVE;
        end else begin
          in_ready = 1'b1;
          if (in_valid) begin
            cmd.accept = 1'b1;
            state_next = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd.update = 1'b1;
        if (sts.emit) begin
          cmd.avg_start = 1'b1;
          state_next    = ST_AVERAGE;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_AVERAGE: begin
        if (sts.div_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_DERIVE: begin
        if (sts.div_done) begin
          cmd.derive_load = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== design/boxavg_datapath.sv =====
// datapath: settings, raster counters, column accumulators, divider, output register
module boxavg_datapath (
  input  logic                                   clk,
  input  logic                                   rst,
  input  boxavg_pkg::ctrl_cmd_t                  cmd,
  output boxavg_pkg::dp_status_t                 sts,
  input  logic                                   cfg_we,
  input  boxavg_pkg::cfg_reg_t                   cfg_index,
  input  logic [boxavg_pkg::CFG_W-1:0]           cfg_data,
  input  logic [boxavg_pkg::CH_W-1:0]            red_in,
  input  logic [boxavg_pkg::CH_W-1:0]            green_in,
  input  logic [boxavg_pkg::CH_W-1:0]            blue_in,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [boxavg_pkg::CH_W-1:0]            red_out,
  output logic [boxavg_pkg::CH_W-1:0]            green_out,
  output logic [boxavg_pkg::CH_W-1:0]            blue_out,
  output logic [boxavg_pkg::COL_W-1:0]           out_column,
  output logic                                   row_end,
  output logic                                   frame_end
);
  import boxavg_pkg::*;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    priority if (v == '0) r = DIM_W'(1);
    else if (v > DIM_W'(MAX_WIDTH)) r = DIM_W'(MAX_WIDTH);
    else r = v;
    return r;
  endfunction

  function automatic logic [BLK_W-1:0] clamp_blk(input logic [BLK_W-1:0] v);
    logic [BLK_W-1:0] r;
    priority if (v == '0) r = BLK_W'(1);
    else if (v > BLK_W'(MAX_BLOCK)) r = BLK_W'(MAX_BLOCK);
    else r = v;
    return r;
  endfunction

  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic [BLK_W-1:0] block_width;
  logic [BLK_W-1:0] block_height;
  logic             cfg_pending;

  logic [DIM_W-1:0]  w_c;
  logic [DIM_W-1:0]  h_c;
  logic [BLK_W-1:0]  bw_c;
  logic [BLK_W-1:0]  bh_c;
  logic [AREA_W-1:0] area;

  logic [DIM_W-1:0] new_w;
  logic [DIM_W-1:0] used_rows;

  logic [COL_W-1:0] pixel_column;
  logic [COL_W-1:0] pixel_row;
  logic [OFS_W-1:0] column_in_block;
  logic [OFS_W-1:0] row_in_block;
  logic [COL_W-1:0] block_column;

  logic col_ok;
  logic row_ok;
  logic last_col;
  logic last_row;

  logic                        hit;
  logic                        first;
  logic                        emit;
  logic                        rend;
  logic                        fend;
  logic [COL_W-1:0]            addr;
  logic [LANES-1:0][CH_W-1:0]  pix;

  logic [LANES-1:0][SUM_W-1:0]  acc_rd;
  logic [LANES-1:0][SUM_W-1:0]  acc_new;
  logic [COL_W-1:0]             clear_addr;
  logic                         ram_we;
  logic [COL_W-1:0]             ram_waddr;
  logic [LANES*SUM_W-1:0]       ram_wdata;

  logic                         div_start;
  logic                         div_done;
  logic [LANES-1:0][SUM_W-1:0]  div_dividend;
  logic [LANES-1:0][AREA_W-1:0] div_divisor;
  logic [LANES-1:0][SUM_W-1:0]  div_quotient;

  // settings
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_W'(RESET_IMAGE_WIDTH);
      image_height <= DIM_W'(RESET_IMAGE_HEIGHT);
      block_width  <= BLK_W'(RESET_BLOCK_WIDTH);
      block_height <= BLK_W'(RESET_BLOCK_HEIGHT);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[DIM_W-1:0];
        REG_BLOCK_WIDTH:  block_width  <= cfg_data[BLK_W-1:0];
        REG_BLOCK_HEIGHT: block_height <= cfg_data[BLK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_pending <= 1'b0;
    end else if (cfg_we) begin
      cfg_pending <= 1'b1;
    end else if (cmd.derive_start) begin
      cfg_pending <= 1'b0;
    end
  end

  assign w_c  = clamp_dim(image_width);
  assign h_c  = clamp_dim(image_height);
  assign bw_c = clamp_blk(block_width);
  assign bh_c = clamp_blk(block_height);
  assign area = AREA_W'(bw_c) * AREA_W'(bh_c);

  // blocks per row and rows covered by whole block rows
  always_ff @(posedge clk) begin
    if (rst) begin
      new_w     <= DIM_W'(RESET_NEW_WIDTH);
      used_rows <= DIM_W'(RESET_USED_ROWS);
    end else if (cmd.derive_load) begin
      new_w     <= div_quotient[0][DIM_W-1:0];
      used_rows <= div_quotient[1][DIM_W-1:0] * DIM_W'(bh_c);
    end
  end

  assign col_ok   = {1'b0, block_column} < new_w;
  assign row_ok   = {1'b0, pixel_row} < used_rows;
  assign last_col = {1'b0, column_in_block} >= bw_c - BLK_W'(1);
  assign last_row = {1'b0, row_in_block} >= bh_c - BLK_W'(1);

  // raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_column    <= '0;
      pixel_row       <= '0;
      column_in_block <= '0;
      row_in_block    <= '0;
      block_column    <= '0;
    end else if (cmd.accept) begin
      if ({1'b0, pixel_column} >= w_c - DIM_W'(1)) begin
        pixel_column    <= '0;
        column_in_block <= '0;
        block_column    <= '0;
        if ({1'b0, pixel_row} >= h_c - DIM_W'(1)) begin
          pixel_row    <= '0;
          row_in_block <= '0;
        end else begin
          pixel_row    <= pixel_row + 1'b1;
          row_in_block <= last_row ? '0 : row_in_block + 1'b1;
        end
      end else begin
        pixel_column <= pixel_column + 1'b1;
        if (last_col) begin
          column_in_block <= '0;
          if (block_column < COL_W'(MAX_WIDTH - 1)) begin
            block_column <= block_column + 1'b1;
          end
        end else begin
          column_in_block <= column_in_block + 1'b1;
        end
      end
    end
  end

  // transaction capture
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      hit           <= col_ok && row_ok;
      first         <= (column_in_block == '0) && (row_in_block == '0);
      emit          <= col_ok && row_ok && last_col && last_row;
      rend          <= {1'b0, block_column} == new_w - DIM_W'(1);
      fend          <= ({1'b0, block_column} == new_w - DIM_W'(1)) &&
                       ({1'b0, pixel_row} >= used_rows - DIM_W'(1));
      addr          <= block_column;
      pix[LANE_RED]   <= red_in;
      pix[LANE_GREEN] <= green_in;
      pix[LANE_BLUE]  <= blue_in;
    end
  end

  // accumulator update
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      acc_new[i] = first ? SUM_W'(pix[i]) : acc_rd[i] + SUM_W'(pix[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr <= '0;
    end else if (cmd.clear_en) begin
      clear_addr <= clear_addr + 1'b1;
    end
  end

  assign ram_we    = cmd.clear_en || (cmd.update && hit);
  assign ram_waddr = cmd.clear_en ? clear_addr : addr;
  assign ram_wdata = cmd.clear_en ? '0 : acc_new;

  boxavg_ram #(
    .WIDTH (LANES * SUM_W),
    .DEPTH (MAX_WIDTH)
  ) u_acc_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (block_column),
    .rdata (acc_rd)
  );

  // shared divider: block averages, or the block grid after a settings change
  always_comb begin
    if (cmd.derive_start) begin
      div_dividend    = '0;
      div_divisor     = '0;
      div_dividend[0] = SUM_W'(w_c);
      div_dividend[1] = SUM_W'(h_c);
      div_divisor[0]  = AREA_W'(bw_c);
      div_divisor[1]  = AREA_W'(bh_c);
      div_divisor[2]  = AREA_W'(1);
    end else begin
      div_dividend = acc_new;
      for (int i = 0; i < LANES; i++) begin
        div_divisor[i] = area;
      end
    end
  end

  assign div_start = cmd.derive_start || cmd.avg_start;

  boxavg_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .done     (div_done)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      red_out    <= div_quotient[LANE_RED][CH_W-1:0];
      green_out  <= div_quotient[LANE_GREEN][CH_W-1:0];
      blue_out   <= div_quotient[LANE_BLUE][CH_W-1:0];
      out_column <= addr;
      row_end    <= rend;
      frame_end  <= fend;
    end
  end

  assign sts.clear_last  = &clear_addr;
  assign sts.cfg_pending = cfg_pending;
  assign sts.emit        = emit;
  assign sts.div_done    = div_done;
  assign sts.out_free    = !out_valid || out_ready;

endmodule

// ===== design/boxavg_checker.sv =====
// port level checks of the box average downscaler and their binding
`include "box_average_downscale_unit_assert.svh"

module boxavg_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic row_end,
  input logic frame_end,
  input logic cfg_we
);

  `BOXAVG_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid, "result lost while stalled")
  `BOXAVG_ASSERT_NEXT(a_one_pixel_in_flight, in_valid && in_ready, !in_ready, "pixel taken back to back")
  `BOXAVG_ASSERT_NEXT(a_cfg_blocks_input, cfg_we, !in_ready, "pixel taken before grid update")
  `BOXAVG_ASSERT_SAME(a_frame_end_on_row_end, out_valid && frame_end, row_end, "frame end off row end")

endmodule

bind box_average_downscale_unit boxavg_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pixel.valid),
  .in_ready  (pixel.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .row_end   (result.row_end),
  .frame_end (result.frame_end),
  .cfg_we    (cfg_we)
);
